// ===== hw/rtl/bctm_pkg.sv =====
// shared types, constants and gamma threshold function for the bloom composite tone mapper
`default_nettype none

package bctm_pkg;

    localparam int unsigned IN_W                     = 20;
    localparam int unsigned CFG_W                    = 15;
    localparam int unsigned OUT_W                    = 8;
    localparam int unsigned CFG_IDX_W                = 2;
    localparam int unsigned FRACTION_BITS            = 12;
    localparam int unsigned GAMMA_TABLE_BITS_DEFAULT = 12;
    localparam int unsigned STRENGTH_SHIFT           = 14;

    localparam int unsigned WEIGHT_W = IN_W + CFG_W;
    localparam int unsigned SUM_W    = IN_W + 3;
    localparam int unsigned LIN_W    = IN_W + 8;
    localparam int unsigned PROD_W   = IN_W + LIN_W + 1;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned WIDE_W   = 192;

    localparam int unsigned FRONT_STAGES  = 4;
    localparam int unsigned GAMMA_STAGES  = OUT_W;
    localparam int unsigned GAMMA_ENTRIES = 1 << OUT_W;

    localparam logic [IN_W-1:0]  FIELD_MAX      = {IN_W{1'b1}};
    localparam logic [CFG_W-1:0] BLOOM_RESET    = CFG_W'(13926);
    localparam logic [CFG_W-1:0] FLARE_RESET    = CFG_W'(9011);

    localparam logic [CFG_IDX_W-1:0] CFG_BLOOM_STRENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FLARE_STRENGTH = CFG_IDX_W'(1);

    // rational curve coefficients scaled by 100
    localparam logic [LIN_W-1:0]  NUM_SLOPE  = LIN_W'(251);
    localparam logic [LIN_W-1:0]  NUM_OFFSET = LIN_W'(3) << FRACTION_BITS;
    localparam logic [LIN_W-1:0]  DEN_SLOPE  = LIN_W'(243);
    localparam logic [LIN_W-1:0]  DEN_OFFSET = LIN_W'(59) << FRACTION_BITS;
    localparam logic [PROD_W-1:0] DEN_CONST  = PROD_W'(14) << (2 * FRACTION_BITS);

    typedef struct packed {
        logic [IN_W-1:0] scene_red;
        logic [IN_W-1:0] scene_green;
        logic [IN_W-1:0] scene_blue;
        logic [IN_W-1:0] bloom_red;
        logic [IN_W-1:0] bloom_green;
        logic [IN_W-1:0] bloom_blue;
        logic [IN_W-1:0] flare_red;
        logic [IN_W-1:0] flare_green;
        logic [IN_W-1:0] flare_blue;
    } t_pixel_in;

    typedef struct packed {
        logic [OUT_W-1:0] out_red;
        logic [OUT_W-1:0] out_green;
        logic [OUT_W-1:0] out_blue;
    } t_pixel_out;

    // smallest t with b^11 * N^5 <= 255^11 * t^5, N = 2^gbits
    function automatic logic [THR_W-1:0] gamma_threshold(input int unsigned b,
                                                         input int unsigned gbits);
        logic [WIDE_W-1:0] lhs;
        logic [WIDE_W-1:0] rhs;
        logic [WIDE_W-1:0] base;
        logic [THR_W-1:0]  lo;
        logic [THR_W-1:0]  hi;
        logic [THR_W-1:0]  mid;
        int                i;
        int                k;
        lhs = WIDE_W'(b);
        for (i = 1; i < 11; i++) begin
            lhs = lhs * WIDE_W'(b);
        end
        lhs  = lhs << (5 * gbits);
        base = WIDE_W'(1);
        for (i = 0; i < 11; i++) begin
            base = base * WIDE_W'(255);
        end
        lo = '0;
        hi = THR_W'(1) << gbits;
        for (i = 0; i < THR_W; i++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                rhs = base;
                for (k = 0; k < 5; k++) begin
                    rhs = rhs * WIDE_W'(mid);
                end
                if (lhs <= rhs) begin
                    hi = mid;
                end else begin
                    lo = mid + THR_W'(1);
                end
            end
        end
        return lo;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bctm_channel.sv =====
// one color channel: composite, filmic curve, bit-serial pipelined divide, gamma search
`default_nettype none

module bctm_channel #(
    parameter int unsigned GAMMA_TABLE_BITS = bctm_pkg::GAMMA_TABLE_BITS_DEFAULT,
    localparam int unsigned NSTAGE =
        bctm_pkg::FRONT_STAGES + GAMMA_TABLE_BITS + bctm_pkg::GAMMA_STAGES
) (
    input  wire logic                        i_clk,
    input  wire logic [NSTAGE-1:0]           i_en,
    input  wire logic [bctm_pkg::IN_W-1:0]   i_scene,
    input  wire logic [bctm_pkg::IN_W-1:0]   i_bloom,
    input  wire logic [bctm_pkg::IN_W-1:0]   i_flare,
    input  wire logic [bctm_pkg::CFG_W-1:0]  i_bloom_strength,
    input  wire logic [bctm_pkg::CFG_W-1:0]  i_flare_strength,
    output logic      [bctm_pkg::OUT_W-1:0]  o_out
);

    localparam int unsigned G    = GAMMA_TABLE_BITS;
    localparam int unsigned T_W  = G + 1;
    localparam int unsigned PW   = bctm_pkg::PROD_W;
    localparam int unsigned WW   = bctm_pkg::WEIGHT_W;
    localparam int unsigned SW   = bctm_pkg::SUM_W;
    localparam int unsigned LW   = bctm_pkg::LIN_W;
    localparam int unsigned IW   = bctm_pkg::IN_W;
    localparam int unsigned OW   = bctm_pkg::OUT_W;
    localparam int unsigned GS   = bctm_pkg::GAMMA_STAGES;
    localparam int unsigned DIV0 = bctm_pkg::FRONT_STAGES;
    localparam int unsigned GAM0 = bctm_pkg::FRONT_STAGES + G;
    localparam logic [T_W-1:0] T_FULL = T_W'(1) << G;

    // gamma thresholds
    logic [T_W-1:0] w_thr [bctm_pkg::GAMMA_ENTRIES];

    for (genvar gi = 0; gi < bctm_pkg::GAMMA_ENTRIES; gi++) begin : g_thr
        localparam logic [T_W-1:0] THR = T_W'(bctm_pkg::gamma_threshold(gi, G));
        assign w_thr[gi] = THR;
    end

    // composite
    logic [IW-1:0] r_scene;
    logic [WW-1:0] r_bloom_prod;
    logic [WW-1:0] r_flare_prod;
    logic [SW-1:0] n_sum;
    logic [IW-1:0] n_v;
    logic [IW-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_scene      <= i_scene;
            r_bloom_prod <= WW'(i_bloom) * WW'(i_bloom_strength);
            r_flare_prod <= WW'(i_flare) * WW'(i_flare_strength);
        end
    end

    always_comb begin
        n_sum = SW'(r_scene)
              + SW'(r_bloom_prod >> bctm_pkg::STRENGTH_SHIFT)
              + SW'(r_flare_prod >> bctm_pkg::STRENGTH_SHIFT);
        n_v   = (n_sum > SW'(bctm_pkg::FIELD_MAX)) ? bctm_pkg::FIELD_MAX : n_sum[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_v <= n_v;
        end
    end

    // curve numerator and denominator
    logic [IW-1:0] r_v3;
    logic [LW-1:0] r_lin_num;
    logic [LW-1:0] r_lin_den;
    logic [PW-1:0] r_num;
    logic [PW-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_v3      <= r_v;
            r_lin_num <= bctm_pkg::NUM_SLOPE * LW'(r_v) + bctm_pkg::NUM_OFFSET;
            r_lin_den <= bctm_pkg::DEN_SLOPE * LW'(r_v) + bctm_pkg::DEN_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_num <= PW'(r_v3) * PW'(r_lin_num);
            r_den <= PW'(r_v3) * PW'(r_lin_den) + bctm_pkg::DEN_CONST;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [PW-1:0] r_rem  [G];
    logic [PW-1:0] r_dden [G];
    logic [G-1:0]  r_q    [G];
    logic          r_sat  [G];

    logic [PW-1:0] d_rem_in [G];
    logic [PW-1:0] d_den_in [G];
    logic [G-1:0]  d_q_in   [G];
    logic          d_sat_in [G];
    logic [PW:0]   d_shift  [G];
    logic [PW:0]   d_diff   [G];
    logic          d_ge     [G];
    logic [PW-1:0] n_rem    [G];
    logic [G-1:0]  n_q      [G];

    always_comb begin
        d_rem_in[0] = r_num;
        d_den_in[0] = r_den;
        d_q_in[0]   = '0;
        d_sat_in[0] = (r_num >= r_den);
        for (int j = 1; j < G; j++) begin
            d_rem_in[j] = r_rem[j-1];
            d_den_in[j] = r_dden[j-1];
            d_q_in[j]   = r_q[j-1];
            d_sat_in[j] = r_sat[j-1];
        end
        for (int j = 0; j < G; j++) begin
            d_shift[j] = {d_rem_in[j], 1'b0};
            d_diff[j]  = d_shift[j] - {1'b0, d_den_in[j]};
            d_ge[j]    = (d_shift[j] >= {1'b0, d_den_in[j]});
            n_rem[j]   = d_ge[j] ? d_diff[j][PW-1:0] : d_shift[j][PW-1:0];
            n_q[j]     = {d_q_in[j][G-2:0], d_ge[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < G; j++) begin
            if (i_en[DIV0+j]) begin
                r_rem[j]  <= n_rem[j];
                r_dden[j] <= d_den_in[j];
                r_q[j]    <= n_q[j];
                r_sat[j]  <= d_sat_in[j];
            end
        end
    end

    // gamma byte, one result bit per stage
    logic [OW-1:0]  r_acc  [GS];
    logic [T_W-1:0] r_t    [GS];

    logic [OW-1:0]  g_acc_in [GS];
    logic [T_W-1:0] g_t_in   [GS];
    logic [OW-1:0]  g_cand   [GS];
    logic [OW-1:0]  n_acc    [GS];

    always_comb begin
        g_acc_in[0] = '0;
        g_t_in[0]   = r_sat[G-1] ? T_FULL : {1'b0, r_q[G-1]};
        for (int k = 1; k < GS; k++) begin
            g_acc_in[k] = r_acc[k-1];
            g_t_in[k]   = r_t[k-1];
        end
        for (int k = 0; k < GS; k++) begin
            g_cand[k] = g_acc_in[k] | (OW'(1) << (OW - 1 - k));
            n_acc[k]  = (w_thr[g_cand[k]] <= g_t_in[k]) ? g_cand[k] : g_acc_in[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < GS; k++) begin
            if (i_en[GAM0+k]) begin
                r_acc[k] <= n_acc[k];
                r_t[k]   <= g_t_in[k];
            end
        end
    end

    assign o_out = r_acc[GS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/bloom_composite_tone_map.sv =====
// top level of the bloom composite tone mapper: handshake, valid pipeline, config registers
// usage:
//   input channel i_in_valid / o_in_stall / i_in_data carries one hdr pixel per transaction
//   (scene, bloom and flare rgb, u8.12). output channel o_out_valid / i_out_stall /
//   o_out_data carries one gamma corrected rgb byte triple per transaction, in input order.
//   config channel i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data writes bloom
//   strength (index 0) and flare strength (index 1), q1.14; o_cfg_ready is always high,
//   other indexes are ignored. write config only while the pipeline is empty.
//   the pipeline is made of the front multiply stages, the divider at one quotient bit per
//   stage and the gamma search at one output bit per stage. throughput: one pixel per
//   cycle while the receiver does not stall. reset clears all valid bits and loads the
//   default strengths (0.85 and 0.55). when the receiver stalls, the output holds and
//   empty stages keep filling; the input stalls only once the stage behind it is
//   occupied and the pipeline cannot move.
`default_nettype none

module bloom_composite_tone_map #(
    parameter int unsigned GAMMA_TABLE_BITS = bctm_pkg::GAMMA_TABLE_BITS_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire bctm_pkg::t_pixel_in               i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output bctm_pkg::t_pixel_out                   o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bctm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bctm_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int unsigned NSTAGE =
        bctm_pkg::FRONT_STAGES + GAMMA_TABLE_BITS + bctm_pkg::GAMMA_STAGES;

    logic [bctm_pkg::CFG_W-1:0] r_bloom_strength;
    logic [bctm_pkg::CFG_W-1:0] r_flare_strength;
    logic [NSTAGE-1:0]          r_vld;
    logic [NSTAGE-1:0]          n_vld;
    logic [NSTAGE-1:0]          en;
    logic                       go;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bloom_strength <= bctm_pkg::BLOOM_RESET;
            r_flare_strength <= bctm_pkg::FLARE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bctm_pkg::CFG_BLOOM_STRENGTH: begin
                    r_bloom_strength <= i_cfg_data;
                end
                bctm_pkg::CFG_FLARE_STRENGTH: begin
                    r_flare_strength <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // a stage loads when it is empty or the whole pipeline advances
    always_comb begin
        go = !r_vld[NSTAGE-1] || !i_out_stall;
        for (int k = 0; k < NSTAGE; k++) begin
            en[k] = !r_vld[k] || go;
        end
        n_vld[0] = en[0] ? i_in_valid : (r_vld[0] && !en[1]);
        for (int k = 1; k < NSTAGE - 1; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : (r_vld[k] && !en[k+1]);
        end
        n_vld[NSTAGE-1] = en[NSTAGE-1] ? r_vld[NSTAGE-2] : r_vld[NSTAGE-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[NSTAGE-1];

    bctm_channel #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_red (
        .i_clk            (i_clk),
        .i_en             (en),
        .i_scene          (i_in_data.scene_red),
        .i_bloom          (i_in_data.bloom_red),
        .i_flare          (i_in_data.flare_red),
        .i_bloom_strength (r_bloom_strength),
        .i_flare_strength (r_flare_strength),
        .o_out            (o_out_data.out_red)
    );

    bctm_channel #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_green (
        .i_clk            (i_clk),
        .i_en             (en),
        .i_scene          (i_in_data.scene_green),
        .i_bloom          (i_in_data.bloom_green),
        .i_flare          (i_in_data.flare_green),
        .i_bloom_strength (r_bloom_strength),
        .i_flare_strength (r_flare_strength),
        .o_out            (o_out_data.out_green)
    );

    bctm_channel #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_blue (
        .i_clk            (i_clk),
        .i_en             (en),
        .i_scene          (i_in_data.scene_blue),
        .i_bloom          (i_in_data.bloom_blue),
        .i_flare          (i_in_data.flare_blue),
        .i_bloom_strength (r_bloom_strength),
        .i_flare_strength (r_flare_strength),
        .o_out            (o_out_data.out_blue)
    );

endmodule

`default_nettype wire
